// File: src/ccm_pkg.sv
// Types shared by the congruence merge block: divider request and response words.
// No dependencies.
package ccm_pkg;

    localparam int DvdW = 64;
    localparam int DvsW = 32;

    typedef struct packed {
        logic            start;
        logic [DvdW-1:0] dividend;
        logic [DvsW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [DvdW-1:0] quotient;
        logic [DvsW-1:0] remainder;
    } t_div_rsp;

endpackage

// File: src/ccm_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
// Depends on ccm_pkg.
module ccm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccm_pkg::t_div_req i_req,
    output ccm_pkg::t_div_rsp o_rsp
);
    import ccm_pkg::*;

    logic [DvdW-1:0] r_quo;
    logic [DvsW:0]   r_rem;
    logic [DvsW-1:0] r_dvs;
    logic [6:0]      r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DvsW:0]   shifted;
    logic            fits;

    assign shifted = {r_rem[DvsW-1:0], r_quo[DvdW-1]};
    assign fits    = shifted >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(DvdW);
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? shifted - {1'b0, r_dvs} : shifted;
                r_quo <= {r_quo[DvdW-2:0], fits};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem[DvsW-1:0];

endmodule

// File: src/ccm_mul.sv
// Registered multiplier: 32-bit unsigned operand times 34-bit signed operand.
// No dependencies.
module ccm_mul (
    input  logic               i_clk,
    input  logic [31:0]        i_a,
    input  logic signed [33:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= $signed({1'b0, i_a}) * i_b;
    end

    assign o_p = r_p;

endmodule

// File: src/crt_congruence_merge.sv
// Top level of the congruence merge: sequencer around a shared divider and multiplier.
// Depends on ccm_pkg, ccm_div and ccm_mul.
//
//   channel | direction | handshake           | payload
//   input   | in        | i_valid / o_ready   | two residues, two moduli, two valid flags
//   output  | out       | o_valid / i_ready   | has_solution, merged residue, merged modulus
//
// An invalid input is answered without the divider. A valid word passes through the
// divider twice to reduce the residues, once per step of the extended Euclidean
// algorithm on the moduli (up to about 46 steps), and up to five more times after it.
// Reset is synchronous and active low and leaves the block idle with no result pending.
// The input is taken only while the sequencer is idle; a finished result waits in the
// output register while the next word may already be accepted.
module crt_congruence_merge (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_first_residue,
    input  logic [31:0] i_first_modulus,
    input  logic        i_first_valid,
    input  logic [31:0] i_second_residue,
    input  logic [31:0] i_second_modulus,
    input  logic        i_second_valid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_has_solution,
    output logic [63:0] o_merged_residue,
    output logic [63:0] o_merged_modulus
);
    import ccm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RED1, S_RED2, S_EGD, S_EGM, S_EGU, S_D1, S_D2,
        S_STEP, S_Q1, S_KM, S_KL, S_KD, S_RM, S_LM, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    logic [31:0] r_r1, n_r1, r_m1, n_m1, r_r2, n_r2, r_m2, n_m2;
    logic [31:0] r_oldr, n_oldr, r_r, n_r, r_q, n_q, r_tmp, n_tmp;
    logic signed [33:0] r_olds, n_olds, r_s, n_s;
    logic [31:0] r_q1, n_q1, r_rem1, n_rem1, r_q2, n_q2, r_step, n_step;
    logic [31:0] r_delta, n_delta, r_inv, n_inv, r_k, n_k;
    logic        r_has, n_has;
    logic [63:0] r_res, n_res, r_lcm, n_lcm;

    logic        r_ov;
    logic        r_oh;
    logic [63:0] r_ores, r_omod;

    t_div_req r_req, n_req;
    t_div_rsp rsp;

    logic [31:0]        mul_a;
    logic signed [33:0] mul_b;
    logic signed [65:0] prod;
    logic signed [33:0] ts;
    logic signed [33:0] inv_s;

    ccm_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(rsp));
    ccm_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(prod));

    assign ts    = r_olds - prod[33:0];
    assign inv_s = r_olds < 0 ? r_olds + $signed({2'b00, r_step}) : r_olds;

    always_comb begin
        mul_a = r_m1;
        mul_b = $signed({2'b00, r_step});
        case (r_state)
            S_EGM:   begin mul_a = r_q;     mul_b = r_s; end
            S_KM:    begin mul_a = r_delta; mul_b = $signed({2'b00, r_inv}); end
            S_RM:    begin mul_a = r_m1;    mul_b = $signed({2'b00, r_k}); end
            default: begin mul_a = r_m1;    mul_b = $signed({2'b00, r_step}); end
        endcase
    end

    always_comb begin
        n_state = r_state; n_pend = r_pend;
        n_r1 = r_r1; n_m1 = r_m1; n_r2 = r_r2; n_m2 = r_m2;
        n_oldr = r_oldr; n_r = r_r; n_q = r_q; n_tmp = r_tmp; n_olds = r_olds; n_s = r_s;
        n_q1 = r_q1; n_rem1 = r_rem1; n_q2 = r_q2; n_step = r_step;
        n_delta = r_delta; n_inv = r_inv; n_k = r_k;
        n_has = r_has; n_res = r_res; n_lcm = r_lcm;
        n_req = r_req;
        n_req.start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_r1 = i_first_residue;  n_m1 = i_first_modulus;
                    n_r2 = i_second_residue; n_m2 = i_second_modulus;
                    if (!i_first_valid || !i_second_valid ||
                        i_first_modulus == '0 || i_second_modulus == '0) begin
                        n_has = 1'b0; n_res = '0; n_lcm = '0; n_pend = 1'b1;
                    end else begin
                        n_req = '{1'b1, {32'd0, i_first_residue}, i_first_modulus};
                        n_state = S_RED1;
                    end
                end
            end
            S_RED1: if (rsp.done) begin
                n_r1 = rsp.remainder;
                n_req = '{1'b1, {32'd0, r_r2}, r_m2};
                n_state = S_RED2;
            end
            S_RED2: if (rsp.done) begin
                n_r2 = rsp.remainder;
                n_oldr = r_m1; n_r = r_m2; n_olds = 34'sd1; n_s = '0;
                n_req = '{1'b1, {32'd0, r_m1}, r_m2};
                n_state = S_EGD;
            end
            S_EGD: if (rsp.done) begin
                n_q = rsp.quotient[31:0];
                n_tmp = rsp.remainder;
                n_state = S_EGM;
            end
            S_EGM: n_state = S_EGU;
            S_EGU: begin
                n_olds = r_s; n_s = ts; n_oldr = r_r; n_r = r_tmp;
                if (r_tmp == '0) begin
                    n_req = '{1'b1, {32'd0, r_r1}, r_r};
                    n_state = S_D1;
                end else begin
                    n_req = '{1'b1, {32'd0, r_r}, r_tmp};
                    n_state = S_EGD;
                end
            end
            S_D1: if (rsp.done) begin
                n_q1 = rsp.quotient[31:0];
                n_rem1 = rsp.remainder;
                n_req = '{1'b1, {32'd0, r_r2}, r_oldr};
                n_state = S_D2;
            end
            S_D2: if (rsp.done) begin
                if (rsp.remainder != r_rem1) begin
                    n_has = 1'b0; n_res = '0; n_lcm = '0; n_pend = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_q2 = rsp.quotient[31:0];
                    n_req = '{1'b1, {32'd0, r_m2}, r_oldr};
                    n_state = S_STEP;
                end
            end
            S_STEP: if (rsp.done) begin
                n_step = rsp.quotient[31:0];
                n_req = '{1'b1, {32'd0, r_q1}, rsp.quotient[31:0]};
                n_state = S_Q1;
            end
            S_Q1: if (rsp.done) begin
                // Difference of the scaled residues, brought into [0, step).
                n_delta = r_q2 - rsp.remainder + ((r_q2 < rsp.remainder) ? r_step : 32'd0);
                n_inv = inv_s[31:0];
                n_state = S_KM;
            end
            S_KM: n_state = S_KL;
            S_KL: begin
                n_req = '{1'b1, prod[63:0], r_step};
                n_state = S_KD;
            end
            S_KD: if (rsp.done) begin
                n_k = rsp.remainder;
                n_state = S_RM;
            end
            S_RM: n_state = S_LM;
            S_LM: begin
                n_res = {32'd0, r_r1} + prod[63:0];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_lcm = prod[63:0];
                n_has = 1'b1;
                n_pend = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        // A finished result leaves for the output register once that is free.
        if (r_pend && (!r_ov || i_ready)) begin
            n_pend = 1'b0;
        end
    end

    // The sequencer stays idle while a finished result still waits for the output stage.
    assign o_ready = (r_state == S_IDLE) && !r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
            r_req   <= '0;
        end else begin
            r_state <= (r_state == S_IDLE && !o_ready) ? S_IDLE : n_state;
            r_req   <= (r_state == S_IDLE && !o_ready) ? '0 : n_req;
            if (r_pend && (!r_ov || i_ready)) begin
                r_pend <= 1'b0;
                r_ov   <= 1'b1;
                r_oh   <= r_has;
                r_ores <= r_res;
                r_omod <= r_lcm;
            end else begin
                if (r_ov && i_ready) begin
                    r_ov <= 1'b0;
                end
                r_pend <= (r_state == S_IDLE && !o_ready) ? r_pend : n_pend;
            end
        end
        if (!(r_state == S_IDLE && !o_ready)) begin
            r_r1 <= n_r1; r_m1 <= n_m1; r_r2 <= n_r2; r_m2 <= n_m2;
            r_has <= n_has; r_res <= n_res; r_lcm <= n_lcm;
        end
        r_oldr <= n_oldr; r_r <= n_r; r_q <= n_q; r_tmp <= n_tmp;
        r_olds <= n_olds; r_s <= n_s;
        r_q1 <= n_q1; r_rem1 <= n_rem1; r_q2 <= n_q2; r_step <= n_step;
        r_delta <= n_delta; r_inv <= n_inv; r_k <= n_k;
    end

    assign o_valid          = r_ov;
    assign o_has_solution   = r_oh;
    assign o_merged_residue = r_ores;
    assign o_merged_modulus = r_omod;

endmodule

// File: src/ccm_chk.sv
// Port-level checks for the congruence merge block, bound to the top level.
// No dependencies.
module ccm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_has_solution,
    input logic [63:0] o_merged_residue,
    input logic [63:0] o_merged_modulus
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_merged_residue))
        else $error("result word changed while stalled");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("block took a second word while busy");

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_has_solution |-> o_merged_residue == '0 && o_merged_modulus == '0)
        else $error("no-solution word carries data");

    a_res_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_has_solution |-> o_merged_residue < o_merged_modulus)
        else $error("merged residue not below merged modulus");

endmodule

bind crt_congruence_merge ccm_chk u_ccm_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_has_solution(o_has_solution),
    .o_merged_residue(o_merged_residue), .o_merged_modulus(o_merged_modulus)
);
